### rtl/blfw_pkg.sv
// Package for the bunch live fraction weighter.
// Holds field widths, fixed-point constants, register indexes and the
// command and status structs shared by the controller and the datapath.
package blfw_pkg;

  localparam int unsigned IDX_W      = 12;
  localparam int unsigned LUMI_W     = 32;
  localparam int unsigned BUSY_W     = 24;
  localparam int unsigned TURN_W     = 32;
  localparam int unsigned FRAC_W     = 17;
  localparam int unsigned WSUM_W     = 61;
  localparam int unsigned LSUM_W     = 44;
  localparam int unsigned PROD_W     = LUMI_W + FRAC_W;
  localparam int unsigned DIV_STEPS  = FRAC_W;
  localparam int unsigned CNT_W      = $clog2(DIV_STEPS);
  localparam int unsigned IN_DATA_W  = 96;
  localparam int unsigned OUT_DATA_W = 72;
  localparam int unsigned CFG_ADDR_W = 3;
  localparam int unsigned CFG_DATA_W = 32;

  localparam int unsigned NUM_BUNCHES_DEF = 3564;

  localparam logic [FRAC_W-1:0] ONE_Q16 = 17'h10000;

  // Register index, taken from the word address bit of the configuration port.
  localparam logic REG_TURN_COUNT = 1'b0;

  typedef struct packed {
    logic load;
    logic frac_start;
    logic mul_en;
    logic acc_en;
    logic avg_start;
    logic res_load;
  } blfw_cmd_t;

  typedef struct packed {
    logic div_done;
    logic last;
  } blfw_stat_t;

endpackage

### rtl/blfw_div.sv
// Restoring divider producing a saturated Q1.16 quotient, one bit per cycle.
// Depends on blfw_pkg for widths and the 1.0 constant.
module blfw_div
  import blfw_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [WSUM_W-1:0] num,
  input  logic [LSUM_W-1:0] den,
  output logic              done,
  output logic [FRAC_W-1:0] quot
);

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [LSUM_W-1:0] rem_r, rem_nxt;
  logic [FRAC_W-1:0] nlo_r, nlo_nxt;
  logic [FRAC_W-1:0] q_r, q_nxt;
  logic              sat_r, sat_nxt;
  logic [LSUM_W:0]   trial;
  logic [LSUM_W:0]   diff;
  logic              ge;

  assign trial = {rem_r, nlo_r[FRAC_W-1]};
  assign ge    = trial >= {1'b0, den};
  assign diff  = trial - {1'b0, den};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    nlo_nxt  = nlo_r;
    q_nxt    = q_r;
    sat_nxt  = sat_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = num[WSUM_W-1:FRAC_W];
      nlo_nxt  = num[FRAC_W-1:0];
      q_nxt    = '0;
      sat_nxt  = num[WSUM_W-1:FRAC_W] >= den;
    end else if (busy_r) begin
      rem_nxt = ge ? diff[LSUM_W-1:0] : trial[LSUM_W-1:0];
      q_nxt   = {q_r[FRAC_W-2:0], ge};
      nlo_nxt = {nlo_r[FRAC_W-2:0], 1'b0};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNT_W'(DIV_STEPS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    nlo_r <= nlo_nxt;
    q_r   <= q_nxt;
    sat_r <= sat_nxt;
  end

  assign done = done_r;
  assign quot = (sat_r || (q_r > ONE_Q16)) ? ONE_Q16 : q_r;

endmodule

### rtl/blfw_dp.sv
// Datapath: item registers, two divider lanes, multipliers and running sums.
// Depends on blfw_pkg and blfw_div; driven by commands from blfw_ctrl.
module blfw_dp
  import blfw_pkg::*;
#(
  parameter int unsigned NUM_BUNCHES = NUM_BUNCHES_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  blfw_cmd_t         cmd,
  output blfw_stat_t        stat,
  input  logic [TURN_W-1:0] turn_count,
  input  logic [IDX_W-1:0]  bunch_index,
  input  logic [LUMI_W-1:0] bunch_lumi,
  input  logic [BUSY_W-1:0] busy_low_prio,
  input  logic [BUSY_W-1:0] busy_high_prio,
  input  logic              last_bunch,
  output logic [FRAC_W-1:0] live_low_prio,
  output logic [FRAC_W-1:0] live_high_prio,
  output logic              busy_overrun,
  output logic [FRAC_W-1:0] avg_low_prio,
  output logic [FRAC_W-1:0] avg_high_prio,
  output logic              avg_valid
);

  logic [IDX_W-1:0]  idx_r;
  logic [LUMI_W-1:0] lumi_r;
  logic [BUSY_W-1:0] blo_r, bhi_r;
  logic              last_r;
  logic [FRAC_W-1:0] flo_r, fhi_r;
  logic              over_r;
  logic [PROD_W-1:0] plo_r, phi_r;
  logic [WSUM_W-1:0] wlo_r, whi_r;
  logic [LSUM_W-1:0] lsum_r;
  logic              avg_mode_r;

  logic              avg_sel;
  logic              t_zero;
  logic              ovr_lo, ovr_hi;
  logic [TURN_W-1:0] diff_lo, diff_hi;
  logic [WSUM_W-1:0] num_lo, num_hi;
  logic [LSUM_W-1:0] den;
  logic [FRAC_W-1:0] q_lo, q_hi;
  logic [FRAC_W-1:0] flo_c, fhi_c;
  logic              done_lo, done_hi;
  logic              in_range;

  assign t_zero  = turn_count == '0;
  assign ovr_lo  = !t_zero && (TURN_W'(blo_r) > turn_count);
  assign ovr_hi  = !t_zero && (TURN_W'(bhi_r) > turn_count);
  assign diff_lo = turn_count - TURN_W'(blo_r);
  assign diff_hi = turn_count - TURN_W'(bhi_r);

  assign avg_sel = cmd.avg_start || (avg_mode_r && !cmd.frac_start);
  assign num_lo  = avg_sel ? wlo_r : WSUM_W'({diff_lo, 16'b0});
  assign num_hi  = avg_sel ? whi_r : WSUM_W'({diff_hi, 16'b0});
  assign den     = avg_sel ? lsum_r : LSUM_W'(turn_count);

  blfw_div u_div_lo (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.frac_start || cmd.avg_start),
    .num   (num_lo),
    .den   (den),
    .done  (done_lo),
    .quot  (q_lo)
  );

  blfw_div u_div_hi (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.frac_start || cmd.avg_start),
    .num   (num_hi),
    .den   (den),
    .done  (done_hi),
    .quot  (q_hi)
  );

  assign flo_c = t_zero ? ONE_Q16 : (ovr_lo ? '0 : q_lo);
  assign fhi_c = t_zero ? ONE_Q16 : (ovr_hi ? '0 : q_hi);

  assign in_range = (idx_r != '0) && ({1'b0, idx_r} < (IDX_W + 1)'(NUM_BUNCHES));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wlo_r      <= '0;
      whi_r      <= '0;
      lsum_r     <= '0;
      avg_mode_r <= 1'b0;
    end else begin
      if (cmd.frac_start) begin
        avg_mode_r <= 1'b0;
      end else if (cmd.avg_start) begin
        avg_mode_r <= 1'b1;
      end
      if (cmd.acc_en && in_range) begin
        wlo_r  <= wlo_r + WSUM_W'(plo_r);
        whi_r  <= whi_r + WSUM_W'(phi_r);
        lsum_r <= lsum_r + LSUM_W'(lumi_r);
      end else if (cmd.res_load && last_r) begin
        wlo_r  <= '0;
        whi_r  <= '0;
        lsum_r <= '0;
      end
    end
    if (cmd.load) begin
      idx_r  <= bunch_index;
      lumi_r <= bunch_lumi;
      blo_r  <= busy_low_prio;
      bhi_r  <= busy_high_prio;
      last_r <= last_bunch;
    end
    if (cmd.mul_en) begin
      flo_r  <= flo_c;
      fhi_r  <= fhi_c;
      over_r <= ovr_lo || ovr_hi;
      plo_r  <= lumi_r * flo_c;
      phi_r  <= lumi_r * fhi_c;
    end
  end

  assign stat.div_done = done_lo && done_hi;
  assign stat.last     = last_r;

  assign live_low_prio  = flo_r;
  assign live_high_prio = fhi_r;
  assign busy_overrun   = over_r;
  assign avg_low_prio   = !last_r ? '0 : ((lsum_r == '0) ? ONE_Q16 : q_lo);
  assign avg_high_prio  = !last_r ? '0 : ((lsum_r == '0) ? ONE_Q16 : q_hi);
  assign avg_valid      = last_r;

endmodule

### rtl/blfw_ctrl.sv
// Controller state machine sequencing one bunch through the datapath.
// Depends on blfw_pkg for the command and status structs.
module blfw_ctrl
  import blfw_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       out_busy,
  input  blfw_stat_t stat,
  output blfw_cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_FSTART,
    S_FWAIT,
    S_MUL,
    S_ACC,
    S_ASTART,
    S_AWAIT,
    S_EMIT
  } state_t;

  state_t state_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      unique case (state_r)
        S_IDLE:   if (in_valid) state_r <= S_FSTART;
        S_FSTART: state_r <= S_FWAIT;
        S_FWAIT:  if (stat.div_done) state_r <= S_MUL;
        S_MUL:    state_r <= S_ACC;
        S_ACC:    state_r <= stat.last ? S_ASTART : S_EMIT;
        S_ASTART: state_r <= S_AWAIT;
        S_AWAIT:  if (stat.div_done) state_r <= S_EMIT;
        S_EMIT:   if (!out_busy) state_r <= S_IDLE;
        default:  state_r <= S_IDLE;
      endcase
    end
  end

  assign in_ready = state_r == S_IDLE;

  always_comb begin
    cmd            = '0;
    cmd.load       = (state_r == S_IDLE) && in_valid;
    cmd.frac_start = state_r == S_FSTART;
    cmd.mul_en     = state_r == S_MUL;
    cmd.acc_en     = state_r == S_ACC;
    cmd.avg_start  = state_r == S_ASTART;
    cmd.res_load   = (state_r == S_EMIT) && !out_busy;
  end

endmodule

### rtl/bunch_live_fraction_weighter.sv
// A bunch is loaded, its live fractions are divided out by the restoring dividers
// (one quotient bit per cycle per lane), weighted and summed; on the last bunch
// the averages are divided as well. No new bunch is taken before the result of the
// last is loaded; the output register lets it wait while the next is taken in.
// Reset: synchronous active-low rst_n clears the sums, turn count and control.
// Depends on blfw_pkg, blfw_ctrl, blfw_dp and blfw_div.
module bunch_live_fraction_weighter
  import blfw_pkg::*;
#(
  parameter int unsigned NUM_BUNCHES = NUM_BUNCHES_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // bunch_index, bunch_lumi, busy_low_prio, busy_high_prio, zero fill
  input  logic [IN_DATA_W-1:0]  in_tdata,
  input  logic                  in_tlast,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // live_low_prio, live_high_prio, busy_overrun, avg_low_prio, avg_high_prio,
  // zero fill
  output logic [OUT_DATA_W-1:0] out_tdata,
  // avg_valid
  output logic                  out_tuser,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic [CFG_DATA_W-1:0] cfg_prdata,
  output logic                  cfg_pready
);

  logic [TURN_W-1:0]     turn_count_r;
  logic                  out_valid_r;
  logic [OUT_DATA_W-1:0] out_data_r;
  logic                  out_user_r;
  logic                  out_busy;
  blfw_cmd_t             cmd;
  blfw_stat_t            stat;
  logic [FRAC_W-1:0]     live_lo, live_hi, avg_lo, avg_hi;
  logic                  over, avg_ok;

  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[2] == REG_TURN_COUNT) ? turn_count_r : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      turn_count_r <= '0;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
                 (cfg_paddr[2] == REG_TURN_COUNT)) begin
      turn_count_r <= cfg_pwdata;
    end
  end

  assign out_busy = out_valid_r && !out_tready;

  blfw_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .out_busy (out_busy),
    .stat     (stat),
    .cmd      (cmd)
  );

  blfw_dp #(
    .NUM_BUNCHES (NUM_BUNCHES)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .stat           (stat),
    .turn_count     (turn_count_r),
    .bunch_index    (in_tdata[11:0]),
    .bunch_lumi     (in_tdata[43:12]),
    .busy_low_prio  (in_tdata[67:44]),
    .busy_high_prio (in_tdata[91:68]),
    .last_bunch     (in_tlast),
    .live_low_prio  (live_lo),
    .live_high_prio (live_hi),
    .busy_overrun   (over),
    .avg_low_prio   (avg_lo),
    .avg_high_prio  (avg_hi),
    .avg_valid      (avg_ok)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.res_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
    if (cmd.res_load) begin
      out_data_r <= OUT_DATA_W'({avg_hi, avg_lo, over, live_hi, live_lo});
      out_user_r <= avg_ok;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

endmodule

### test/tb.sv
`timescale 1ns / 1ps
// Testbench for bunch_live_fraction_weighter: predicts live fractions and weighted averages
// in a scoreboard class and checks every result transaction against them.
// Depends on blfw_pkg and the RTL of the block only.
module tb;
  import blfw_pkg::*;

  localparam int unsigned IDLE_LIMIT   = 2000;
  localparam int unsigned DRAIN_CYCLES = 60;
  localparam int unsigned PHASE_ITEMS  = 48;
  localparam int unsigned WRAP_ITEMS   = 24;

  typedef struct packed {
    logic [IDX_W-1:0]  idx;
    logic [LUMI_W-1:0] lumi;
    logic [BUSY_W-1:0] busy_low;
    logic [BUSY_W-1:0] busy_high;
    logic              last;
  } bunch_t;

  typedef struct {
    logic [FRAC_W-1:0] live_low;
    logic [FRAC_W-1:0] live_high;
    logic              overrun;
    logic [FRAC_W-1:0] avg_low;
    logic [FRAC_W-1:0] avg_high;
    logic              avg_valid;
  } fractions_t;

  typedef struct packed {
    logic [OUT_DATA_W-4*FRAC_W-2:0] pad;
    logic [FRAC_W-1:0]              avg_high;
    logic [FRAC_W-1:0]              avg_low;
    logic                           overrun;
    logic [FRAC_W-1:0]              live_high;
    logic [FRAC_W-1:0]              live_low;
  } fraction_word_t;

  class fraction_scoreboard;
    logic [TURN_W-1:0] turn_count;
    logic [WSUM_W-1:0] wsum_low;
    logic [WSUM_W-1:0] wsum_high;
    logic [LSUM_W-1:0] lumi_sum;
    fractions_t        expected_q[$];
    int unsigned       errors;

    function new();
      turn_count = '0;
      wsum_low   = '0;
      wsum_high  = '0;
      lumi_sum   = '0;
      errors     = 0;
    endfunction

    function logic [FRAC_W-1:0] live_fraction(logic [BUSY_W-1:0] busy);
      logic [63:0] t;
      t = turn_count;
      if (t == 0) return ONE_Q16;
      if (busy > t) return '0;
      return FRAC_W'(((t - busy) << 16) / t);
    endfunction

    function logic [FRAC_W-1:0] weighted_average(logic [WSUM_W-1:0] wsum);
      logic [63:0] q;
      q = wsum / lumi_sum;
      return (q > ONE_Q16) ? ONE_Q16 : q[FRAC_W-1:0];
    endfunction

    function void note_bunch(bunch_t b);
      fractions_t r;
      r.live_low  = live_fraction(b.busy_low);
      r.live_high = live_fraction(b.busy_high);
      r.overrun   = (turn_count != 0) && (b.busy_low > turn_count || b.busy_high > turn_count);
      r.avg_low   = '0;
      r.avg_high  = '0;
      r.avg_valid = b.last;
      if (b.idx != 0 && b.idx < NUM_BUNCHES_DEF) begin
        wsum_low  = wsum_low + WSUM_W'(b.lumi) * WSUM_W'(r.live_low);
        wsum_high = wsum_high + WSUM_W'(b.lumi) * WSUM_W'(r.live_high);
        lumi_sum  = lumi_sum + LSUM_W'(b.lumi);
      end
      if (b.last) begin
        if (lumi_sum == 0) begin
          r.avg_low  = ONE_Q16;
          r.avg_high = ONE_Q16;
        end else begin
          r.avg_low  = weighted_average(wsum_low);
          r.avg_high = weighted_average(wsum_high);
        end
        wsum_low  = '0;
        wsum_high = '0;
        lumi_sum  = '0;
      end
      expected_q.push_back(r);
    endfunction

    function void compare_field(string field_name, logic [FRAC_W-1:0] want,
                                logic [FRAC_W-1:0] got);
      if (want !== got) begin
        $error("%s: expected %0d, got %0d", field_name, want, got);
        errors++;
      end
    endfunction

    function void check_result(logic [OUT_DATA_W-1:0] data, logic avg_valid);
      fraction_word_t w;
      fractions_t     e;
      if (expected_q.size() == 0) begin
        $error("result transaction with nothing expected: tdata %h", data);
        errors++;
        return;
      end
      e = expected_q.pop_front();
      w = fraction_word_t'(data);
      compare_field("live_low_prio", e.live_low, w.live_low);
      compare_field("live_high_prio", e.live_high, w.live_high);
      compare_field("busy_overrun", FRAC_W'(e.overrun), FRAC_W'(w.overrun));
      compare_field("avg_low_prio", e.avg_low, w.avg_low);
      compare_field("avg_high_prio", e.avg_high, w.avg_high);
      compare_field("avg_valid", FRAC_W'(e.avg_valid), FRAC_W'(avg_valid));
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic [IN_DATA_W-1:0]  in_tdata;
  logic                  in_tlast;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tuser;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic                  cfg_psel;
  logic                  cfg_penable;
  logic                  cfg_pwrite;
  logic [CFG_ADDR_W-1:0] cfg_paddr;
  logic [CFG_DATA_W-1:0] cfg_pwdata;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  fraction_scoreboard sb;
  bit          gaps_on   = 1'b1;
  bit          stalls_on = 1'b1;
  int unsigned burst_left = 0;
  int unsigned stall_left = 0;
  int unsigned idle_cycles = 0;

  bunch_live_fraction_weighter #(.NUM_BUNCHES(NUM_BUNCHES_DEF)) DUT (
    .clk(clk), .rst_n(rst_n),
    .in_tdata(in_tdata), .in_tlast(in_tlast), .in_tvalid(in_tvalid), .in_tready(in_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser), .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(negedge clk) begin
    if (stall_left != 0) begin
      out_tready <= 1'b0;
      stall_left--;
    end else begin
      out_tready <= 1'b1;
      if (stalls_on && $urandom_range(0, 5) == 0) stall_left = $urandom_range(1, 40);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata, out_tuser);
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_psel && cfg_penable && cfg_pready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("[bunch_live_fraction_weighter] ERROR");
      $finish;
    end
  end

  function automatic bunch_t make_bunch(logic [IDX_W-1:0] idx, logic [LUMI_W-1:0] lumi,
                                        logic [BUSY_W-1:0] busy_low,
                                        logic [BUSY_W-1:0] busy_high, logic last);
    bunch_t b;
    b.idx       = idx;
    b.lumi      = lumi;
    b.busy_low  = busy_low;
    b.busy_high = busy_high;
    b.last      = last;
    return b;
  endfunction

  function automatic logic [BUSY_W-1:0] pick_busy();
    logic [32:0] v;
    logic [31:0] t;
    t = sb.turn_count;
    case ($urandom_range(0, 5))
      0: v = '0;
      1: v = {1'b0, t};
      2: v = {1'b0, t} + 33'd1;
      3: v = {1'b0, $urandom_range(0, t)};
      default: v = {1'b0, $urandom};
    endcase
    if (v > 33'hFFFFFF) v = {1'b0, $urandom};
    return v[BUSY_W-1:0];
  endfunction

  function automatic bunch_t random_bunch(logic last);
    bunch_t b;
    case ($urandom_range(0, 9))
      0: b.idx = '0;
      1: b.idx = IDX_W'($urandom_range(NUM_BUNCHES_DEF, 4095));
      2: b.idx = IDX_W'($urandom);
      default: b.idx = IDX_W'($urandom_range(1, NUM_BUNCHES_DEF - 1));
    endcase
    case ($urandom_range(0, 5))
      0: b.lumi = '0;
      1: b.lumi = $urandom_range(1, 65536);
      default: b.lumi = $urandom;
    endcase
    b.busy_low  = pick_busy();
    b.busy_high = pick_busy();
    b.last      = last;
    return b;
  endfunction

  task automatic send_bunch(bunch_t b);
    int unsigned gap;
    gap = 0;
    if (burst_left == 0) begin
      if (gaps_on) gap = $urandom_range(1, 20);
      burst_left = $urandom_range(1, 30);
    end
    burst_left--;
    if (gap != 0) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata  <= IN_DATA_W'({b.busy_high, b.busy_low, b.lumi, b.idx});
    in_tlast  <= b.last;
    do @(posedge clk); while (!in_tready);
    sb.note_bunch(b);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_turn_count(logic [TURN_W-1:0] value);
    @(negedge clk);
    cfg_psel    <= 1'b1;
    cfg_pwrite  <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr   <= {REG_TURN_COUNT, 2'b00};
    cfg_pwdata  <= value;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    sb.turn_count = value;
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
  endtask

  task automatic run_random_frames(int unsigned items);
    int unsigned sent;
    int unsigned len;
    sent = 0;
    while (sent < items) begin
      len = ($urandom_range(0, 7) == 0) ? 1 : $urandom_range(2, 16);
      for (int unsigned k = 0; k < len; k++) send_bunch(random_bunch(k == len - 1));
      sent += len;
    end
  endtask

  initial begin
    logic [TURN_W-1:0] turns;
    sb          = new();
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    in_tlast    = 1'b0;
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
    cfg_paddr   = '0;
    cfg_pwdata  = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // The turn count is still at its reset value of zero here.
    send_bunch(make_bunch(12'd0, 32'd0, 24'd0, 24'd0, 1'b1));
    send_bunch(make_bunch(12'd1, 32'hFFFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 1'b0));
    send_bunch(make_bunch(12'd4095, 32'hFFFFFFFF, 24'h123456, 24'd0, 1'b1));
    wait_drained();

    write_turn_count(32'd1000);
    send_bunch(make_bunch(IDX_W'(NUM_BUNCHES_DEF - 1), 32'h03E80000, 24'd0, 24'd1000, 1'b0));
    send_bunch(make_bunch(IDX_W'(NUM_BUNCHES_DEF), 32'h00ABCDEF, 24'd1001, 24'd500, 1'b0));
    send_bunch(make_bunch(12'd2, 32'd0, 24'd999, 24'd1, 1'b0));
    send_bunch(make_bunch(12'd100, 32'h00010000, 24'd250, 24'd750, 1'b0));
    send_bunch(make_bunch(12'd7, 32'hFFFFFFFF, 24'hFFFFFF, 24'd0, 1'b1));
    wait_drained();

    write_turn_count(32'hFFFFFFFF);
    send_bunch(make_bunch(12'd1, 32'hFFFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 1'b0));
    send_bunch(make_bunch(12'd2048, 32'd1, 24'd0, 24'd1, 1'b0));
    send_bunch(make_bunch(12'd3, 32'h80000000, 24'h800000, 24'h7FFFFF, 1'b1));
    wait_drained();

    write_turn_count(32'd1);
    send_bunch(make_bunch(12'd1, 32'd12345, 24'd0, 24'd1, 1'b0));
    send_bunch(make_bunch(12'd2, 32'd5, 24'd2, 24'd0, 1'b0));
    send_bunch(make_bunch(12'd0, 32'd99, 24'd1, 24'd1, 1'b1));
    wait_drained();

    write_turn_count(32'h00FFFFFF);
    send_bunch(make_bunch(12'd2730, 32'hAAAAAAAA, 24'h555555, 24'hAAAAAA, 1'b0));
    send_bunch(make_bunch(12'd1365, 32'h55555555, 24'hFFFFFF, 24'hFFFFFE, 1'b1));
    wait_drained();

    for (int unsigned p = 0; p < 7; p++) begin
      case (p)
        0: turns = $urandom;
        1: turns = $urandom_range(1, 64);
        2: turns = $urandom_range(32'h00800000, 32'h02000000);
        3: turns = 32'hFFFFFFFF;
        4: turns = '0;
        5: turns = $urandom_range(100, 5000);
        default: turns = 32'd1;
      endcase
      gaps_on   = (p != 2);
      stalls_on = (p % 3 != 1);
      write_turn_count(turns);
      run_random_frames(PHASE_ITEMS);
      wait_drained();
    end

    // One long back-to-back frame of full luminosity at a turn count of one
    // gives averages of exactly one and zero.
    gaps_on   = 1'b0;
    stalls_on = 1'b0;
    write_turn_count(32'd1);
    for (int unsigned i = 0; i < WRAP_ITEMS; i++) begin
      send_bunch(make_bunch(IDX_W'(1 + i % (NUM_BUNCHES_DEF - 1)), 32'hFFFFFFFF, 24'd0,
                            24'd1, i == WRAP_ITEMS - 1));
    end
    wait_drained();

    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("[bunch_live_fraction_weighter] OK");
    end else begin
      $display("[bunch_live_fraction_weighter] ERROR");
    end
    $finish;
  end

endmodule
